// ----- hw/rtl/nsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsd_pkg
// Shared types, constants and the factor schedule for the nonuniform sample
// derivative block.
// ----------------------------------------------------------------------------
package nsd_pkg;

    localparam int TICKS_PER_SECOND   = 1000000;
    localparam int PAD_TICKS          = 10;
    localparam int SEED_SPACING_TICKS = 1000;

    localparam int TIME_W   = 40;   // input time stamp
    localparam int VEL_W    = 32;   // Q16.16 velocity
    localparam int HT_W     = 42;   // stored time, signed
    localparam int DIFF_W   = 44;   // time differences and factor values, signed
    localparam int MAG_W    = 43;   // factor magnitude
    localparam int LIMB_W   = 16;
    localparam int NLIMBS   = 17;
    localparam int BIG_W    = LIMB_W * NLIMBS;      // product magnitude
    localparam int ACC_W    = BIG_W + 2;            // signed numerator sum
    localparam int QUO_W    = 35;
    localparam int DSH_W    = BIG_W + QUO_W - 1;    // shifted divisor
    localparam int CUR_W    = LIMB_W + MAG_W + 1;
    localparam int CARRY_W  = CUR_W - LIMB_W;
    localparam int LIMB_CNT_W = $clog2(NLIMBS);
    localparam int DIV_CNT_W  = $clog2(QUO_W);

    localparam logic [1:0] TERM_DEN = 2'd3;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_SEED   = 1'b1;

    typedef enum logic [2:0] {
        RULE_FOUR     = 3'd0,
        RULE_THREE    = 3'd1,
        RULE_TWO      = 3'd2,
        RULE_FALLBACK = 3'd3,
        RULE_SEED     = 3'd4
    } rule_t;

    typedef enum logic [3:0] {
        FAC_ONE,
        FAC_P,
        FAC_Q,
        FAC_R,
        FAC_PQ,
        FAC_PR,
        FAC_QR,
        FAC_D0,
        FAC_ND1,
        FAC_D2,
        FAC_N3,
        FAC_N2,
        FAC_TPS
    } fac_t;

    typedef struct packed {
        logic                    operation;
        logic [TIME_W-1:0]       sample_time;
        logic signed [VEL_W-1:0] velocity;
        logic signed [VEL_W-1:0] fallback_accel;
    } in_beat_t;

    typedef struct packed {
        logic signed [VEL_W-1:0] acceleration;
        logic [2:0]              rule_used;
        logic                    saturated;
        logic                    divide_fault;
    } out_beat_t;

    typedef struct packed {
        logic capture;
        logic decode;
        logic term_start;
        logic mul_step;
        logic mul_first;
        fac_t fac;
        logic acc_add;
        logic den_load;
        logic div_start;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        rule_t rule;
    } status_t;

    // Factor schedule: term 0..2 are numerator terms, TERM_DEN the denominator.
    function automatic fac_t fac_code(input rule_t rule, input logic [1:0] term,
                                      input logic [2:0] idx);
        fac_t code;
        code = FAC_ONE;
        if (term == TERM_DEN) begin
            if (rule == RULE_FOUR) begin
                case (idx)
                    3'd0:    code = FAC_P;
                    3'd1:    code = FAC_Q;
                    3'd2:    code = FAC_R;
                    3'd3:    code = FAC_PQ;
                    3'd4:    code = FAC_PR;
                    3'd5:    code = FAC_QR;
                    default: code = FAC_ONE;
                endcase
            end else begin
                code = FAC_P;
            end
        end else if (rule == RULE_FOUR) begin
            case (idx)
                3'd0, 3'd1:
                begin
                    code = (term == 2'd0) ? FAC_Q : FAC_P;
                end
                3'd2, 3'd3:
                begin
                    code = (term == 2'd2) ? FAC_Q : FAC_R;
                end
                3'd4:
                begin
                    case (term)
                        2'd0:    code = FAC_QR;
                        2'd1:    code = FAC_PR;
                        default: code = FAC_PQ;
                    endcase
                end
                3'd5:
                begin
                    case (term)
                        2'd0:    code = FAC_D0;
                        2'd1:    code = FAC_ND1;
                        default: code = FAC_D2;
                    endcase
                end
                3'd6:    code = FAC_TPS;
                default: code = FAC_ONE;
            endcase
        end else begin
            if (idx == 3'd0) begin
                code = (rule == RULE_THREE) ? FAC_N3 : FAC_N2;
            end else begin
                code = FAC_TPS;
            end
        end
        return code;
    endfunction

    function automatic logic [2:0] fac_count(input rule_t rule, input logic [1:0] term);
        logic [2:0] n;
        if (rule == RULE_FOUR) begin
            n = (term == TERM_DEN) ? 3'd6 : 3'd7;
        end else begin
            n = (term == TERM_DEN) ? 3'd1 : 3'd2;
        end
        return n;
    endfunction

endpackage

// ----- hw/rtl/nonuniform_sample_derivative.sv -----
`timescale 1ns / 1ps
// Sequence: capture, decode and dispatch; seed and fallback beats then go straight to
// finish, the other rules walk the factor schedule limb by limb (four-point: 27 factors
// of 17 limbs) and then the 35 divider steps before finish.
// Throughput: one beat at a time; a new beat is taken once the previous result is
// in the output register. The 16 x 43 limb multiplier and the 1-bit divider set it.
// Reset: rst_n asynchronous, clears control and restores history to zero velocity
// at times -20000, -10000 and 0 ticks.
// ----------------------------------------------------------------------------
// nonuniform_sample_derivative
// Four-point derivative on unevenly spaced samples, with three-point, two-point,
// fallback and seed rules; exact rational arithmetic, truncated and saturated to Q16.16.
// ----------------------------------------------------------------------------
module nonuniform_sample_derivative (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  nsd_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output nsd_pkg::out_beat_t out_data
);

    nsd_pkg::cmd_t    cmd;
    nsd_pkg::status_t stat;

    nsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    nsd_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .out_data (out_data),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// ----- hw/rtl/nsd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsd_ctrl
// Sequencer: walks the factor schedule limb by limb, then the divider steps,
// and owns both handshakes.
// ----------------------------------------------------------------------------
module nsd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  nsd_pkg::status_t stat,
    output nsd_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DISPATCH,
        S_TERM,
        S_MUL,
        S_ACCUM,
        S_DIVS,
        S_DIV,
        S_FINISH
    } state_t;

    state_t                             state_reg, state_next;
    logic [nsd_pkg::LIMB_CNT_W-1:0]     limb_reg, limb_next;
    logic [2:0]                         fac_reg, fac_next;
    logic [1:0]                         term_reg, term_next;
    logic [nsd_pkg::DIV_CNT_W-1:0]      cnt_reg, cnt_next;
    logic                               out_valid_reg, out_valid_next;
    logic                               out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        limb_next  = limb_reg;
        fac_next   = fac_reg;
        term_next  = term_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.fac    = nsd_pkg::fac_code(stat.rule, term_reg, fac_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                if (stat.rule == nsd_pkg::RULE_SEED || stat.rule == nsd_pkg::RULE_FALLBACK)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    term_next  = 2'd0;
                    state_next = S_TERM;
                end
            end
            S_TERM:
            begin
                cmd.term_start = 1'b1;
                fac_next       = 3'd0;
                limb_next      = '0;
                state_next     = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_step  = 1'b1;
                cmd.mul_first = (limb_reg == '0);
                if (limb_reg == nsd_pkg::LIMB_CNT_W'(nsd_pkg::NLIMBS - 1))
                begin
                    limb_next = '0;
                    if (fac_reg == nsd_pkg::fac_count(stat.rule, term_reg) - 3'd1)
                    begin
                        state_next = S_ACCUM;
                    end
                    else
                    begin
                        fac_next = fac_reg + 3'd1;
                    end
                end
                else
                begin
                    limb_next = limb_reg + 1'b1;
                end
            end
            S_ACCUM:
            begin
                if (term_reg == nsd_pkg::TERM_DEN)
                begin
                    cmd.den_load = 1'b1;
                    state_next   = S_DIVS;
                end
                else
                begin
                    cmd.acc_add = 1'b1;
                    if (stat.rule == nsd_pkg::RULE_FOUR && term_reg != 2'd2)
                    begin
                        term_next = term_reg + 2'd1;
                    end
                    else
                    begin
                        term_next = nsd_pkg::TERM_DEN;
                    end
                    state_next = S_TERM;
                end
            end
            S_DIVS:
            begin
                cmd.div_start = 1'b1;
                cnt_next      = '0;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == nsd_pkg::DIV_CNT_W'(nsd_pkg::QUO_W - 1))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            limb_reg      <= '0;
            fac_reg       <= '0;
            term_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limb_reg      <= limb_next;
            fac_reg       <= fac_next;
            term_reg      <= term_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!$past(out_valid_reg) || out_free))
        else $error("result loaded over a pending beat");
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");
    a_limb_range: assert property (@(posedge clk) disable iff (!rst_n)
        limb_reg <= nsd_pkg::LIMB_CNT_W'(nsd_pkg::NLIMBS - 1))
        else $error("limb counter out of range");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> in_stall)
        else $error("second beat accepted while busy");
`endif

endmodule

// ----- hw/rtl/nsd_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsd_datapath
// History registers, limb-serial multiplier, signed accumulator, restoring
// divider and the output register.
// ----------------------------------------------------------------------------
module nsd_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  nsd_pkg::in_beat_t  in_data,
    output nsd_pkg::out_beat_t out_data,
    input  nsd_pkg::cmd_t      cmd,
    output nsd_pkg::status_t   stat
);

    localparam int DW = nsd_pkg::DIFF_W;
    localparam int HW = nsd_pkg::HT_W;
    localparam int VW = nsd_pkg::VEL_W;

    // captured beat
    logic                          op_reg;
    logic [nsd_pkg::TIME_W-1:0]    t_reg;
    logic signed [VW-1:0]          v_reg;
    logic signed [VW-1:0]          fb_reg;

    // history, oldest first
    logic signed [VW-1:0]          pv_reg [3];
    logic signed [HW-1:0]          pt_reg [3];
    nsd_pkg::rule_t                rule_reg;

    // factor sources
    logic signed [DW-1:0]          p_reg, q_reg, r_reg, pq_reg, pr_reg, qr_reg;
    logic signed [DW-1:0]          d0_reg, nd1_reg, d2_reg, n3_reg, n2_reg;

    // multiplier and accumulator
    logic [nsd_pkg::BIG_W-1:0]     x_reg;
    logic                          xneg_reg;
    logic [nsd_pkg::CARRY_W-1:0]   carry_reg;
    logic signed [nsd_pkg::ACC_W-1:0] acc_reg;
    logic [nsd_pkg::BIG_W-1:0]     den_reg;
    logic                          dneg_reg;

    // divider
    logic [nsd_pkg::ACC_W-1:0]     num_reg;
    logic [nsd_pkg::DSH_W-1:0]     dsh_reg;
    logic [nsd_pkg::QUO_W-1:0]     quot_reg;
    logic                          rneg_reg;
    logic                          fault_reg;

    nsd_pkg::out_beat_t            out_reg;

    logic signed [DW-1:0]          te;
    logic signed [DW-1:0]          pte [3];
    logic signed [DW-1:0]          ve;
    logic signed [DW-1:0]          pve [3];
    nsd_pkg::rule_t                rule_dec;
    logic signed [DW-1:0]          fval;
    logic                          fneg;
    logic [DW-1:0]                 fabs;
    logic [nsd_pkg::CUR_W-1:0]     cur;
    logic [nsd_pkg::CARRY_W-1:0]   carry_in;
    logic signed [nsd_pkg::ACC_W-1:0] xext;
    logic [nsd_pkg::ACC_W-1:0]     acc_abs;
    logic [nsd_pkg::DSH_W:0]       sub;
    nsd_pkg::out_beat_t            res;

    assign te = DW'($signed({1'b0, t_reg}));
    assign ve = DW'(v_reg);
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pte[i] = DW'(pt_reg[i]);
            pve[i] = DW'(pv_reg[i]);
        end
    end

    always_comb
    begin
        if (op_reg == nsd_pkg::OP_SEED)
        begin
            rule_dec = nsd_pkg::RULE_SEED;
        end
        else if (te > pte[2])
        begin
            rule_dec = nsd_pkg::RULE_FOUR;
        end
        else if (te > pte[1])
        begin
            rule_dec = nsd_pkg::RULE_THREE;
        end
        else if (te > pte[0])
        begin
            rule_dec = nsd_pkg::RULE_TWO;
        end
        else
        begin
            rule_dec = nsd_pkg::RULE_FALLBACK;
        end
    end

    // factor select
    always_comb
    begin
        case (cmd.fac)
            nsd_pkg::FAC_P:   fval = p_reg;
            nsd_pkg::FAC_Q:   fval = q_reg;
            nsd_pkg::FAC_R:   fval = r_reg;
            nsd_pkg::FAC_PQ:  fval = pq_reg;
            nsd_pkg::FAC_PR:  fval = pr_reg;
            nsd_pkg::FAC_QR:  fval = qr_reg;
            nsd_pkg::FAC_D0:  fval = d0_reg;
            nsd_pkg::FAC_ND1: fval = nd1_reg;
            nsd_pkg::FAC_D2:  fval = d2_reg;
            nsd_pkg::FAC_N3:  fval = n3_reg;
            nsd_pkg::FAC_N2:  fval = n2_reg;
            nsd_pkg::FAC_TPS: fval = DW'(nsd_pkg::TICKS_PER_SECOND);
            default:          fval = DW'(1);
        endcase
        fneg = fval[DW-1];
        fabs = fneg ? DW'(-fval) : DW'(fval);
    end

    assign carry_in = cmd.mul_first ? '0 : carry_reg;
    assign cur = nsd_pkg::CUR_W'(x_reg[nsd_pkg::LIMB_W-1:0])
               * nsd_pkg::CUR_W'(fabs[nsd_pkg::MAG_W-1:0])
               + nsd_pkg::CUR_W'(carry_in);

    assign xext    = $signed({2'b00, x_reg});
    assign acc_abs = acc_reg[nsd_pkg::ACC_W-1] ? nsd_pkg::ACC_W'(-acc_reg)
                                               : nsd_pkg::ACC_W'(acc_reg);
    assign sub     = {1'b0, nsd_pkg::DSH_W'(num_reg)} - {1'b0, dsh_reg};

    // final sign, saturation and rule selection
    always_comb
    begin
        res              = '0;
        res.rule_used    = rule_reg;
        case (rule_reg)
            nsd_pkg::RULE_FOUR, nsd_pkg::RULE_THREE, nsd_pkg::RULE_TWO:
            begin
                if (fault_reg)
                begin
                    res.divide_fault = 1'b1;
                end
                else if (!rneg_reg)
                begin
                    if (quot_reg > nsd_pkg::QUO_W'(32'h7FFF_FFFF))
                    begin
                        res.acceleration = 32'sh7FFF_FFFF;
                        res.saturated    = 1'b1;
                    end
                    else
                    begin
                        res.acceleration = $signed(quot_reg[VW-1:0]);
                    end
                end
                else
                begin
                    if (quot_reg > nsd_pkg::QUO_W'(32'h8000_0000))
                    begin
                        res.acceleration = $signed(32'h8000_0000);
                        res.saturated    = 1'b1;
                    end
                    else
                    begin
                        res.acceleration = $signed(VW'(-quot_reg[VW-1:0]));
                    end
                end
            end
            nsd_pkg::RULE_FALLBACK:
            begin
                res.acceleration = fb_reg;
            end
            default:
            begin
                res.acceleration = '0;
            end
        endcase
    end

    // control-side registers: history and rule
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg[0] <= '0;
            pv_reg[1] <= '0;
            pv_reg[2] <= '0;
            pt_reg[0] <= -HW'(20000);
            pt_reg[1] <= -HW'(10000);
            pt_reg[2] <= '0;
            rule_reg  <= nsd_pkg::RULE_SEED;
        end
        else if (cmd.decode)
        begin
            rule_reg <= rule_dec;
            case (rule_dec)
                nsd_pkg::RULE_FOUR:
                begin
                    pv_reg[0] <= pv_reg[1];
                    pv_reg[1] <= pv_reg[2];
                    pv_reg[2] <= v_reg;
                    pt_reg[0] <= pt_reg[1];
                    pt_reg[1] <= pt_reg[2];
                    pt_reg[2] <= te[HW-1:0];
                end
                nsd_pkg::RULE_THREE:
                begin
                    pv_reg[2] <= v_reg;
                    pt_reg[2] <= te[HW-1:0];
                end
                nsd_pkg::RULE_TWO:
                begin
                    pv_reg[1] <= pv_reg[0];
                    pv_reg[2] <= v_reg;
                    pt_reg[0] <= pt_reg[0] - HW'(nsd_pkg::PAD_TICKS);
                    pt_reg[1] <= pt_reg[0];
                    pt_reg[2] <= te[HW-1:0];
                end
                nsd_pkg::RULE_FALLBACK:
                begin
                    pv_reg[0] <= v_reg;
                    pv_reg[1] <= v_reg;
                    pv_reg[2] <= v_reg;
                    pt_reg[0] <= HW'(te - DW'(2 * nsd_pkg::PAD_TICKS));
                    pt_reg[1] <= HW'(te - DW'(nsd_pkg::PAD_TICKS));
                    pt_reg[2] <= te[HW-1:0];
                end
                default:
                begin
                    pv_reg[0] <= v_reg;
                    pv_reg[1] <= v_reg;
                    pv_reg[2] <= v_reg;
                    pt_reg[0] <= HW'(te - DW'(2 * nsd_pkg::SEED_SPACING_TICKS));
                    pt_reg[1] <= HW'(te - DW'(nsd_pkg::SEED_SPACING_TICKS));
                    pt_reg[2] <= te[HW-1:0];
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= in_data.operation;
            t_reg  <= in_data.sample_time;
            v_reg  <= in_data.velocity;
            fb_reg <= in_data.fallback_accel;
        end
        if (cmd.decode)
        begin
            // differences against the history before it moves
            p_reg   <= te - pte[0];
            q_reg   <= te - pte[1];
            r_reg   <= te - pte[2];
            pq_reg  <= pte[1] - pte[0];
            pr_reg  <= pte[2] - pte[0];
            qr_reg  <= pte[2] - pte[1];
            d0_reg  <= ve - pve[0];
            nd1_reg <= pve[1] - ve;
            d2_reg  <= ve - pve[2];
            n3_reg  <= DW'(3) * ve - DW'(4) * pve[1] + pve[0];
            n2_reg  <= ve - pve[0];
            acc_reg <= '0;
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= xneg_reg ? acc_reg - xext : acc_reg + xext;
        end
        if (cmd.term_start)
        begin
            x_reg    <= nsd_pkg::BIG_W'(1);
            xneg_reg <= 1'b0;
        end
        else if (cmd.mul_step)
        begin
            // advance one limb: new limb enters at the top
            x_reg     <= {cur[nsd_pkg::LIMB_W-1:0], x_reg[nsd_pkg::BIG_W-1:nsd_pkg::LIMB_W]};
            carry_reg <= cur[nsd_pkg::CUR_W-1:nsd_pkg::LIMB_W];
            if (cmd.mul_first)
            begin
                xneg_reg <= xneg_reg ^ fneg;
            end
        end
        if (cmd.den_load)
        begin
            den_reg  <= x_reg;
            dneg_reg <= xneg_reg;
        end
        if (cmd.div_start)
        begin
            num_reg   <= acc_abs;
            rneg_reg  <= acc_reg[nsd_pkg::ACC_W-1] ^ dneg_reg;
            fault_reg <= (den_reg == '0);
            dsh_reg   <= {den_reg, (nsd_pkg::QUO_W - 1)'(0)};
            quot_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!sub[nsd_pkg::DSH_W])
            begin
                num_reg <= sub[nsd_pkg::ACC_W-1:0];
            end
            quot_reg <= {quot_reg[nsd_pkg::QUO_W-2:0], !sub[nsd_pkg::DSH_W]};
            dsh_reg  <= dsh_reg >> 1;
        end
        if (cmd.out_load)
        begin
            out_reg <= res;
        end
    end

    assign out_data  = out_reg;
    assign stat.rule = rule_reg;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives timestamped velocity beats into the nonuniform sample derivative
// block and checks every result against an exact wide-integer derivative
// predictor. Covers the four-, three- and two-point rules, fallback, seeding,
// saturation and extreme times, then a long random run with back-pressure.
// ----------------------------------------------------------------------------
module testbench;

    typedef logic signed [319:0] wide_t;

    localparam longint TIME_MAX = (64'd1 << nsd_pkg::TIME_W) - 1;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    nsd_pkg::in_beat_t  in_data;
    logic               out_valid;
    logic               out_stall;
    nsd_pkg::out_beat_t out_data;

    // history copy, oldest first
    longint    hist_vel [3];
    longint    hist_time [3];
    nsd_pkg::out_beat_t accel_expected [$];
    int        error_count;
    bit        calm;
    bit        hold_req;
    int        hold_left;

    nonuniform_sample_derivative u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50000000;
        $display("testbench: done, errors");
        $finish;
    end

    // divide exactly, truncate toward zero, clip to Q16.16
    task automatic divide_clip(input wide_t num, input wide_t den,
                               inout nsd_pkg::out_beat_t r);
        wide_t quo;
        if (den == 0)
        begin
            r.divide_fault = 1'b1;
            return;
        end
        quo = num / den;
        if (quo > wide_t'(32'sh7FFFFFFF))
        begin
            r.acceleration = 32'h7FFFFFFF;
            r.saturated    = 1'b1;
        end
        else if (quo < -wide_t'(64'sh80000000))
        begin
            r.acceleration = 32'h80000000;
            r.saturated    = 1'b1;
        end
        else
        begin
            r.acceleration = quo[31:0];
        end
    endtask

    task automatic fill_history(input longint v, input longint t, input longint gap);
        hist_vel[0]  = v;
        hist_vel[1]  = v;
        hist_vel[2]  = v;
        hist_time[0] = t - 2 * gap;
        hist_time[1] = t - gap;
        hist_time[2] = t;
    endtask

    task automatic derive_accel(input nsd_pkg::in_beat_t b, output nsd_pkg::out_beat_t r);
        longint t;
        longint v;
        wide_t  p;
        wide_t  q;
        wide_t  s;
        wide_t  tps;
        wide_t  num;
        t   = longint'({24'd0, b.sample_time});
        v   = longint'(b.velocity);
        tps = nsd_pkg::TICKS_PER_SECOND;
        p   = t - hist_time[0];
        q   = t - hist_time[1];
        s   = t - hist_time[2];
        r   = '0;
        if (b.operation == nsd_pkg::OP_SEED)
        begin
            fill_history(v, t, nsd_pkg::SEED_SPACING_TICKS);
            r.rule_used = nsd_pkg::RULE_SEED;
        end
        else if (t > hist_time[2])
        begin
            num = q * q * s * s * (q - s) * wide_t'(v - hist_vel[0]) * tps
                - p * p * s * s * (p - s) * wide_t'(v - hist_vel[1]) * tps
                + p * p * q * q * (p - q) * wide_t'(v - hist_vel[2]) * tps;
            divide_clip(num, p * q * s * (p - q) * (p - s) * (q - s), r);
            hist_vel[0]  = hist_vel[1];
            hist_vel[1]  = hist_vel[2];
            hist_vel[2]  = v;
            hist_time[0] = hist_time[1];
            hist_time[1] = hist_time[2];
            hist_time[2] = t;
            r.rule_used  = nsd_pkg::RULE_FOUR;
        end
        else if (t > hist_time[1])
        begin
            num = wide_t'(3 * v - 4 * hist_vel[1] + hist_vel[0]) * tps;
            divide_clip(num, p, r);
            hist_vel[2]  = v;
            hist_time[2] = t;
            r.rule_used  = nsd_pkg::RULE_THREE;
        end
        else if (t > hist_time[0])
        begin
            divide_clip(wide_t'(v - hist_vel[0]) * tps, p, r);
            hist_vel[2]  = v;
            hist_vel[1]  = hist_vel[0];
            hist_time[2] = t;
            hist_time[1] = hist_time[0];
            hist_time[0] = hist_time[0] - nsd_pkg::PAD_TICKS;
            r.rule_used  = nsd_pkg::RULE_TWO;
        end
        else
        begin
            r.acceleration = b.fallback_accel;
            fill_history(v, t, nsd_pkg::PAD_TICKS);
            r.rule_used    = nsd_pkg::RULE_FALLBACK;
        end
    endtask

    // one beat: optional gap, hold until accepted, then predict
    task automatic send_beat(input logic op, input longint t, input longint v,
                             input longint fb);
        nsd_pkg::in_beat_t  b;
        nsd_pkg::out_beat_t r;
        b.operation      = op;
        b.sample_time    = t[nsd_pkg::TIME_W-1:0];
        b.velocity       = v[31:0];
        b.fallback_accel = fb[31:0];
        if (!calm && $urandom_range(0, 99) < 29)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        derive_accel(b, r);
        accel_expected.push_back(r);
    endtask

    task automatic go_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (accel_expected.size() != 0) @(posedge clk);
    endtask

    function automatic longint rand_vel();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 2)
            return longint'($signed($urandom()));
        if (sel < 8)
            return hist_vel[2] + $urandom_range(0, 131072) - 65536;
        return longint'($signed($urandom_range(0, 511)) - 256);
    endfunction

    function automatic longint rand_in(input longint lo, input longint hi);
        longint span;
        if (lo < 0)
            lo = 0;
        if (hi > TIME_MAX)
            hi = TIME_MAX;
        if (lo > hi)
            return -1;
        span = hi - lo;
        if (span > 64'hFFFF_FFFF)
            span = 64'hFFFF_FFFF;
        return lo + longint'($urandom_range(0, 32'(span)));
    endfunction

    task automatic random_beat();
        int     sel;
        longint t;
        sel = $urandom_range(0, 99);
        t   = -1;
        if (sel < 70)
            t = rand_in(hist_time[2] + 1, hist_time[2] +
                        (($urandom_range(0, 9) == 0) ? $urandom_range(1, 3)
                                                     : $urandom_range(1, 3000)));
        else if (sel < 78)
            t = rand_in(hist_time[1] + 1, hist_time[2]);
        else if (sel < 84)
            t = rand_in(hist_time[0] + 1, hist_time[1]);
        else if (sel < 88)
            t = rand_in(0, hist_time[0]);
        if (sel >= 94)
            send_beat(1'($urandom_range(0, 1)), {$urandom(), $urandom()} & TIME_MAX,
                      longint'($signed($urandom())), longint'($signed($urandom())));
        else if (t < 0 || sel >= 88)
            send_beat(nsd_pkg::OP_SEED, rand_in(0, 64'd5000000), rand_vel(),
                      longint'($signed($urandom())));
        else
            send_beat(nsd_pkg::OP_SAMPLE, t, rand_vel(), longint'($signed($urandom())));
    endtask

    task automatic test_rules();
        send_beat(nsd_pkg::OP_SAMPLE, 1000, 65536, 0);          // forward from reset history
        send_beat(nsd_pkg::OP_SAMPLE, 1000, 131072, 0);         // three-point
        send_beat(nsd_pkg::OP_SAMPLE, 0, -65536, 0);            // two-point
        send_beat(nsd_pkg::OP_SAMPLE, 0, 5, 32'sh12345678);     // three-point
        send_beat(nsd_pkg::OP_SEED, 5000, 300000, 0);
        send_beat(nsd_pkg::OP_SAMPLE, 5500, 300000, 0);         // zero numerator
        send_beat(nsd_pkg::OP_SAMPLE, 6100, -400000, 0);
        send_beat(nsd_pkg::OP_SAMPLE, 6700, 1000, 0);
        send_beat(nsd_pkg::OP_SAMPLE, 7000, 2000, 0);
        go_quiet();
    endtask

    task automatic test_saturation();
        send_beat(nsd_pkg::OP_SEED, 1000, 0, 0);
        send_beat(nsd_pkg::OP_SAMPLE, 1001, 32'sh7FFFFFFF, 0);
        send_beat(nsd_pkg::OP_SAMPLE, 1002, -64'sd2147483648, 0);
        send_beat(nsd_pkg::OP_SAMPLE, 1002, 32'sh7FFFFFFF, 0);
        send_beat(nsd_pkg::OP_SAMPLE, 1001, -64'sd2147483648, 0);
        go_quiet();
    endtask

    task automatic test_extreme_times();
        send_beat(nsd_pkg::OP_SEED, TIME_MAX, -64'sd2147483648, 32'sh7FFFFFFF);
        send_beat(nsd_pkg::OP_SAMPLE, TIME_MAX, 32'sh7FFFFFFF, 0);
        send_beat(nsd_pkg::OP_SAMPLE, 0, 1, -64'sd2147483648);
        send_beat(nsd_pkg::OP_SAMPLE, TIME_MAX, -1, 0);
        send_beat(nsd_pkg::OP_SEED, 0, 0, -1);
        send_beat(nsd_pkg::OP_SAMPLE, 0, 7, 0);
        go_quiet();
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            calm = (i >= count / 3) && (i < count / 3 + 150);
            random_beat();
        end
        calm = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 20; i++)
            random_beat();
        go_quiet();
    endtask

    // receiver: random stall, plus a long hold when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (hold_req)
            begin
                hold_left = 3000;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= !calm && ($urandom_range(0, 99) < 29);
            end
        end
    end

    always @(posedge clk)
    begin
        nsd_pkg::out_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (accel_expected.size() == 0)
            begin
                $error("result beat with nothing expected");
                error_count++;
            end
            else
            begin
                want = accel_expected.pop_front();
                if (out_data.acceleration !== want.acceleration)
                begin
                    $error("acceleration: expected %h, got %h", want.acceleration,
                           out_data.acceleration);
                    error_count++;
                end
                if (out_data.rule_used !== want.rule_used)
                begin
                    $error("rule_used: expected %0d, got %0d", want.rule_used,
                           out_data.rule_used);
                    error_count++;
                end
                if (out_data.saturated !== want.saturated)
                begin
                    $error("saturated: expected %b, got %b", want.saturated,
                           out_data.saturated);
                    error_count++;
                end
                if (out_data.divide_fault !== want.divide_fault)
                begin
                    $error("divide_fault: expected %b, got %b", want.divide_fault,
                           out_data.divide_fault);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        int drain;
        error_count = 0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        hist_vel[0] = 0;
        hist_vel[1] = 0;
        hist_vel[2] = 0;
        hist_time[0] = -20000;
        hist_time[1] = -10000;
        hist_time[2] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_rules();
        test_saturation();
        test_extreme_times();
        test_backpressure();
        test_random(1200);
        go_quiet();
        drain = 0;
        while (drain < 600)
        begin
            @(posedge clk);
            drain++;
        end
        if (error_count == 0 && accel_expected.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/nsd_pkg.sv
hw/rtl/nsd_ctrl.sv
hw/rtl/nsd_datapath.sv
hw/rtl/nonuniform_sample_derivative.sv
tb/testbench.sv
